>>> hdl/c2ie_pkg.sv
// Package for the COMET II style instruction executor.
// Holds shared types, command, status and opcode codes. No dependencies.
package c2ie_pkg;

    localparam int MemWords = 65536;
    localparam int MemAw    = $clog2(MemWords);
    localparam logic [15:0] END_PC = 16'h805A;

    typedef enum logic [2:0] {
        CMD_WRMEM = 3'd0,
        CMD_RDMEM = 3'd1,
        CMD_RDREG = 3'd2,
        CMD_EXEC  = 3'd3,
        CMD_RESTART = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_HALT = 2'd1,
        ST_BADOP = 2'd2,
        ST_BADREG = 2'd3
    } status_e;

    // Opcodes
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_LD   = 8'h10;
    localparam logic [7:0] OP_ST   = 8'h11;
    localparam logic [7:0] OP_LAD  = 8'h12;
    localparam logic [7:0] OP_LDR  = 8'h14;
    localparam logic [7:0] OP_ADDA = 8'h20;
    localparam logic [7:0] OP_SUBA = 8'h21;
    localparam logic [7:0] OP_ADDL = 8'h22;
    localparam logic [7:0] OP_SUBL = 8'h23;
    localparam logic [7:0] OP_ADDAR = 8'h24;
    localparam logic [7:0] OP_SUBAR = 8'h25;
    localparam logic [7:0] OP_ADDLR = 8'h26;
    localparam logic [7:0] OP_SUBLR = 8'h27;
    localparam logic [7:0] OP_AND  = 8'h30;
    localparam logic [7:0] OP_OR   = 8'h31;
    localparam logic [7:0] OP_XOR  = 8'h32;
    localparam logic [7:0] OP_ANDR = 8'h34;
    localparam logic [7:0] OP_ORR  = 8'h35;
    localparam logic [7:0] OP_XORR = 8'h36;
    localparam logic [7:0] OP_CPA  = 8'h40;
    localparam logic [7:0] OP_CPL  = 8'h41;
    localparam logic [7:0] OP_CPAR = 8'h44;
    localparam logic [7:0] OP_CPLR = 8'h45;
    localparam logic [7:0] OP_SLA  = 8'h50;
    localparam logic [7:0] OP_SRA  = 8'h51;
    localparam logic [7:0] OP_SLL  = 8'h52;
    localparam logic [7:0] OP_SRL  = 8'h53;
    localparam logic [7:0] OP_JMI  = 8'h61;
    localparam logic [7:0] OP_JNZ  = 8'h62;
    localparam logic [7:0] OP_JZE  = 8'h63;
    localparam logic [7:0] OP_JUMP = 8'h64;
    localparam logic [7:0] OP_JPL  = 8'h65;
    localparam logic [7:0] OP_JOV  = 8'h66;
    localparam logic [7:0] OP_PUSH = 8'h70;
    localparam logic [7:0] OP_POP  = 8'h71;
    localparam logic [7:0] OP_CALL = 8'h80;
    localparam logic [7:0] OP_RET  = 8'h81;

    // One queued command from the front end.
    typedef struct packed {
        cmd_e        cmd;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [3:0]  sel;
    } cmd_item_t;

    typedef struct packed {
        status_e     status;
        logic [15:0] rword;
        logic [15:0] pc;
        logic [2:0]  flags;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE, S_F1, S_W1, S_F2, S_W2, S_EA, S_DRD, S_DWAIT, S_EXE, S_OUT
    } exec_state_e;

    function automatic logic [2:0] cmp_flags(input logic [15:0] a, input logic [15:0] b,
                                             input logic is_signed);
        logic lt;
        begin
            lt = is_signed ? ($signed(a) < $signed(b)) : (a < b);
            cmp_flags = {1'b0, lt, a == b};
        end
    endfunction

endpackage

>>> hdl/c2ie_front.sv
// Front end: accepts command requests and queues them for the back end.
// Depends on c2ie_pkg.
module c2ie_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2ie_pkg::cmd_item_t in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output c2ie_pkg::cmd_item_t q_item
);
    import c2ie_pkg::*;

    // Two-entry queue.
    cmd_item_t  mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end
endmodule

>>> hdl/c2ie_back.sv
// Back end: runs memory commands, register reads, restarts and one-instruction steps.
// Depends on c2ie_pkg; holds the word memory and the architectural state.
module c2ie_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         start_address,
    input  logic [15:0]         stack_start,
    input  logic                q_valid,
    output logic                q_ready,
    input  c2ie_pkg::cmd_item_t q_item,
    output logic                res_valid,
    input  logic                res_ready,
    output c2ie_pkg::result_t   res_data
);
    import c2ie_pkg::*;

    logic [15:0] mem [MemWords];
    logic [15:0] rd_data_reg;
    logic        mwe;
    logic [MemAw-1:0] maddr;
    logic [15:0] mwdata;

    exec_state_e st_reg, st_next;
    cmd_item_t   cur_reg, cur_next;
    logic [15:0] gr_reg [7];
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [2:0]  fl_reg, fl_next;
    logic        halt_reg, halt_next;
    logic [15:0] w1_reg, w1_next, w2_reg, w2_next, ea_reg, ea_next;
    logic        gr_we;
    logic [2:0]  gr_wi;
    logic [15:0] gr_wd;
    result_t     out_reg, out_next;
    logic        ov_reg, ov_next;

    logic [7:0]  op;
    logic [3:0]  ra, rb;
    logic [15:0] a, b, m;
    logic        ra_ok, rb_ok, two_word_ok, is_jump;
    logic [16:0] sum17;
    logic [15:0] res;
    logic        of;
    logic        sign;
    logic [31:0] shl, shr;

    assign op = w1_reg[15:8];
    assign ra = w1_reg[7:4];
    assign rb = w1_reg[3:0];
    assign ra_ok = ra != 4'd0 && ra <= 4'd7;
    assign rb_ok = rb != 4'd0 && rb <= 4'd7;
    assign a = ra_ok ? gr_reg[ra[2:0] - 3'd1] : 16'd0;
    assign b = rb_ok ? gr_reg[rb[2:0] - 3'd1] : 16'd0;
    assign m = rd_data_reg;
    assign sign = a[15];
    assign is_jump = op inside {[OP_JMI:OP_JOV]};
    assign two_word_ok = op inside {[OP_LD:OP_LAD], [OP_ADDA:OP_SUBL], [OP_AND:OP_XOR],
                                    OP_CPA, OP_CPL, [OP_SLA:OP_SRL], [OP_JMI:OP_JOV],
                                    OP_PUSH, OP_CALL};
    assign q_ready = st_reg == S_IDLE && !ov_reg;
    assign res_valid = ov_reg;
    assign res_data = out_reg;

    // Shift datapath; count is the effective address.
    always_comb begin
        shl = {16'd0, a} << ea_reg[4:0];
        shr = {a, 16'd0} >> ea_reg[4:0];
    end

    // ALU for the execute step. Operand b comes from a register (RR forms)
    // or from the registered memory read.
    always_comb begin
        logic [15:0] bb;
        bb = op[2] ? b : m;
        res = 16'd0;
        of = 1'b0;
        sum17 = 17'd0;
        case (op)
            OP_LD, OP_LDR: res = bb;
            OP_ADDA, OP_ADDAR: begin
                sum17 = {1'b0, a} + {1'b0, bb};
                res = sum17[15:0];
                of = ~(a[15] ^ bb[15]) & (a[15] ^ res[15]);
            end
            OP_SUBA, OP_SUBAR: begin
                sum17 = {1'b0, a} - {1'b0, bb};
                res = sum17[15:0];
                of = (a[15] ^ bb[15]) & (a[15] ^ res[15]);
            end
            OP_ADDL, OP_ADDLR: begin
                sum17 = {1'b0, a} + {1'b0, bb};
                res = sum17[15:0];
                of = sum17[16];
            end
            OP_SUBL, OP_SUBLR: begin
                sum17 = {1'b0, a} - {1'b0, bb};
                res = sum17[15:0];
                of = sum17[16];
            end
            OP_AND, OP_ANDR: res = a & bb;
            OP_OR, OP_ORR:   res = a | bb;
            OP_XOR, OP_XORR: res = a ^ bb;
            OP_SLA: begin
                if (ea_reg == 16'd0) res = a;
                else if (ea_reg <= 16'd15) begin
                    res = {sign, shl[14:0]};
                    of = shl[15];
                end else res = {sign, 15'd0};
            end
            OP_SRA: begin
                if (ea_reg == 16'd0) res = a;
                else if (ea_reg <= 16'd15) begin
                    res = shr[31:16] | (sign ? ~(16'hFFFF >> ea_reg[3:0]) : 16'd0);
                    of = shr[15];
                end else begin
                    res = {16{sign}};
                    of = sign;
                end
            end
            OP_SLL: begin
                if (ea_reg == 16'd0) res = a;
                else if (ea_reg <= 16'd16) begin
                    res = shl[15:0];
                    of = shl[16];
                end
            end
            OP_SRL: begin
                if (ea_reg == 16'd0) res = a;
                else if (ea_reg <= 16'd16) begin
                    res = shr[31:16];
                    of = shr[15];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        logic take;
        logic [15:0] idx;
        st_next = st_reg;
        cur_next = cur_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        fl_next = fl_reg;
        halt_next = halt_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        ea_next = ea_reg;
        out_next = out_reg;
        ov_next = ov_reg && !res_ready;
        mwe = 1'b0;
        maddr = MemAw'(pc_reg);
        mwdata = cur_reg.wdata;
        gr_we = 1'b0;
        gr_wi = ra[2:0] - 3'd1;
        gr_wd = res;
        take = 1'b0;
        idx = (rb == 4'd0 || rb > 4'd7) ? 16'd0 : gr_reg[rb[2:0] - 3'd1];
        case (st_reg)
            S_IDLE: begin
                if (q_valid && !ov_reg) begin
                    cur_next = q_item;
                    out_next.status = ST_OK;
                    out_next.rword = 16'd0;
                    st_next = S_OUT;
                    case (q_item.cmd)
                        CMD_WRMEM: begin
                            mwe = 1'b1;
                            maddr = MemAw'(q_item.addr);
                            mwdata = q_item.wdata;
                        end
                        CMD_RDMEM: begin
                            maddr = MemAw'(q_item.addr);
                            st_next = S_DWAIT;
                        end
                        CMD_RDREG: begin
                            if (q_item.sel == 4'd0) out_next.rword = {13'd0, fl_reg};
                            else if (q_item.sel <= 4'd7)
                                out_next.rword = gr_reg[q_item.sel[2:0] - 3'd1];
                            else if (q_item.sel == 4'd8) out_next.rword = pc_reg;
                            else if (q_item.sel == 4'd9) out_next.rword = sp_reg;
                            else out_next.status = ST_BADREG;
                        end
                        CMD_EXEC: begin
                            if (halt_reg) out_next.status = ST_HALT;
                            else if (pc_reg == END_PC) begin
                                halt_next = 1'b1;
                                out_next.status = ST_HALT;
                            end else begin
                                maddr = MemAw'(pc_reg);
                                pc_next = pc_reg + 16'd1;
                                st_next = S_W1;
                            end
                        end
                        CMD_RESTART: begin
                            pc_next = start_address;
                            sp_next = stack_start;
                            halt_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DWAIT: begin
                out_next.rword = rd_data_reg;
                st_next = S_OUT;
            end
            S_W1: begin
                w1_next = rd_data_reg;
                st_next = S_F1;
            end
            S_F1: begin
                // Decode first word; one-word forms finish or read the stack.
                st_next = S_OUT;
                if (w1_reg == 16'd0) begin
                    halt_next = 1'b1;
                    out_next.status = ST_HALT;
                end else if (op == OP_NOP) begin
                end else if (op inside {OP_LDR, [OP_ADDAR:OP_SUBLR], [OP_ANDR:OP_XORR],
                                        OP_CPAR, OP_CPLR}) begin
                    if (!ra_ok || !rb_ok) out_next.status = ST_BADREG;
                    else if (op == OP_CPAR || op == OP_CPLR)
                        fl_next = cmp_flags(a, b, op == OP_CPAR);
                    else begin
                        gr_we = 1'b1;
                        fl_next = {of, res[15], res == 16'd0};
                    end
                end else if (op == OP_POP) begin
                    if (!ra_ok) out_next.status = ST_BADREG;
                    else begin
                        maddr = MemAw'(sp_reg);
                        st_next = S_DRD;
                    end
                end else if (op == OP_RET) begin
                    if (sp_reg == END_PC) pc_next = END_PC;
                    else begin
                        maddr = MemAw'(sp_reg);
                        st_next = S_DRD;
                    end
                end else begin
                    maddr = MemAw'(pc_reg);
                    pc_next = pc_reg + 16'd1;
                    st_next = S_W2;
                end
            end
            S_W2: begin
                w2_next = rd_data_reg;
                st_next = S_F2;
            end
            S_F2: begin
                st_next = S_OUT;
                if (w2_reg == 16'd0) begin
                    halt_next = 1'b1;
                    out_next.status = ST_HALT;
                end else if (!two_word_ok) out_next.status = ST_BADOP;
                else if (rb > 4'd7) out_next.status = ST_BADREG;
                else begin
                    ea_next = w2_reg + idx;
                    st_next = S_EA;
                end
            end
            S_EA: begin
                st_next = S_OUT;
                if (is_jump) begin
                    case (op)
                        OP_JMI:  take = fl_reg[1];
                        OP_JNZ:  take = !fl_reg[0];
                        OP_JZE:  take = fl_reg[0];
                        OP_JUMP: take = 1'b1;
                        OP_JPL:  take = !fl_reg[1] && !fl_reg[0];
                        default: take = fl_reg[2];
                    endcase
                    if (take) pc_next = ea_reg;
                end else if (op == OP_PUSH) begin
                    sp_next = sp_reg - 16'd1;
                    mwe = 1'b1;
                    maddr = MemAw'(sp_reg - 16'd1);
                    mwdata = ea_reg;
                end else if (op == OP_CALL) begin
                    sp_next = sp_reg - 16'd1;
                    mwe = 1'b1;
                    maddr = MemAw'(sp_reg - 16'd1);
                    mwdata = pc_reg;
                    pc_next = ea_reg;
                end else if (!ra_ok) out_next.status = ST_BADREG;
                else if (op == OP_ST) begin
                    mwe = 1'b1;
                    maddr = MemAw'(ea_reg);
                    mwdata = a;
                end else if (op == OP_LAD) begin
                    gr_we = 1'b1;
                    gr_wd = ea_reg;
                end else if (op inside {[OP_SLA:OP_SRL]}) begin
                    gr_we = 1'b1;
                    fl_next = {of, res[15], res == 16'd0};
                end else begin
                    maddr = MemAw'(ea_reg);
                    st_next = S_DRD;
                end
            end
            S_DRD: begin
                // Keep the data address on the port so the read stays valid.
                maddr = (op == OP_POP || op == OP_RET) ? MemAw'(sp_reg) : MemAw'(ea_reg);
                st_next = S_EXE;
            end
            S_EXE: begin
                st_next = S_OUT;
                if (op == OP_POP) begin
                    gr_we = 1'b1;
                    gr_wd = m;
                    sp_next = sp_reg + 16'd1;
                end else if (op == OP_RET) begin
                    pc_next = m;
                    sp_next = sp_reg + 16'd1;
                end else if (op == OP_CPA || op == OP_CPL)
                    fl_next = cmp_flags(a, m, op == OP_CPA);
                else begin
                    gr_we = 1'b1;
                    fl_next = {of, res[15], res == 16'd0};
                end
            end
            S_OUT: begin
                out_next.pc = pc_reg;
                out_next.flags = fl_reg;
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mwe) mem[maddr] <= mwdata;
        rd_data_reg <= mem[maddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            pc_reg <= start_address;
            sp_reg <= stack_start;
            fl_reg <= 3'd0;
            halt_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int i = 0; i < 7; i++) gr_reg[i] <= 16'd0;
        end else begin
            st_reg <= st_next;
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            fl_reg <= fl_next;
            halt_reg <= halt_next;
            ov_reg <= ov_next;
            if (gr_we) gr_reg[gr_wi] <= gr_wd;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        ea_reg <= ea_next;
        out_reg <= out_next;
    end
endmodule

>>> hdl/comet2_instruction_executor.sv
// Top level of the COMET II style instruction executor.
// Depends on c2ie_pkg, c2ie_front and c2ie_back.
//
// Usage: each request on the s_ channel is one command (write memory, read
// memory, read register, execute one instruction, restart). Exactly one
// result leaves on the m_ channel for each request, in order.
// A front queue of two entries accepts requests while the back end works.
// Timing: memory writes, register reads and restarts go from acceptance
// to the output state; a memory read first waits for the registered read;
// an execute goes straight to the output when the processor is halted or PR
// sits at the end sentinel, otherwise its length is set by the single memory
// port, which serves the first fetch, the second fetch and one data access
// in turn, each with a registered read. One request is worked on at a time:
// the back end takes no new request until its result has been taken.
// Reset (aresetn low, synchronous) clears the registers and flags, loads
// PR and SP from the configuration registers and empties the queue; the
// memory is not cleared. When the receiver stalls, the result is held in
// the output register and the back end waits; the queue keeps taking
// requests until it is full.
module comet2_instruction_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], target_address[18:3], write_word[34:19], reg_select[38:35]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], read_word[17:2], pc_now[33:18], flag_bits[36:34]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import c2ie_pkg::*;

    logic [15:0] start_address_reg, stack_start_reg;
    cmd_item_t   in_item, q_item;
    logic        q_valid, q_ready;
    result_t     res;

    localparam logic [0:0] CFG_START = 1'b0;
    localparam logic [0:0] CFG_STACK = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= 16'd0;
            stack_start_reg <= 16'hFFFF;
        end else if (cfg_we) begin
            if (cfg_index == CFG_START) start_address_reg <= cfg_data;
            if (cfg_index == CFG_STACK) stack_start_reg <= cfg_data;
        end
    end

    assign in_item.cmd   = cmd_e'(s_tdata[2:0]);
    assign in_item.addr  = s_tdata[18:3];
    assign in_item.wdata = s_tdata[34:19];
    assign in_item.sel   = s_tdata[38:35];

    c2ie_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    c2ie_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .start_address(start_address_reg), .stack_start(stack_start_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
    );

    assign m_tdata = {3'd0, res.flags, res.pc, res.rword, res.status};

`ifndef ASSERT_OFF
    // A result sits stable on the output until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // The back end takes a queued request only when its output is free.
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |-> !m_tvalid)
        else $error("request taken with result pending");
`endif
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for comet2_instruction_executor: runs directed and random programs and
// compares every result with an in-bench model of the processor. Depends on c2ie_pkg.
module tb_top;
    import c2ie_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    comet2_instruction_executor u_dut (.*);

    always #5 aclk = ~aclk;

    // Model state of the processor.
    logic [15:0] cpu_mem [0:65535];
    bit          mem_valid [0:65535];
    logic [15:0] cpu_gr [1:7];
    logic [15:0] cpu_pc, cpu_sp, cfg_start, cfg_stack;
    logic [2:0]  cpu_flags;
    bit          cpu_halted;

    result_t     expected_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;      // never used; hold_cycles drives the stall
    int          hold_cycles = 0;
    logic [15:0] code_base;            // never used by the bench

    function automatic logic [15:0] mrd(input logic [15:0] a);
        return cpu_mem[a];
    endfunction

    function automatic void mwr(input logic [15:0] a, input logic [15:0] v);
        cpu_mem[a] = v;
        mem_valid[a] = 1'b1;
    endfunction

    function automatic void put_flags(input logic [16:0] v, input logic of_bit);
        cpu_flags = {of_bit, v[15], v[15:0] == 16'h0};
    endfunction

    function automatic logic [2:0] compare(input logic [15:0] a, input logic [15:0] b,
                                           input bit signed_cmp);
        bit lt;
        lt = signed_cmp ? ($signed(a) < $signed(b)) : (a < b);
        return {1'b0, lt, a == b};
    endfunction

    // Executes one instruction on the model and gives its status.
    function automatic status_e execute_instruction();
        logic [15:0] w1, w2, a, b, ea, sign;
        logic [16:0] res;
        logic [7:0]  op;
        logic [3:0]  ra, rb;
        logic        of_bit;
        bit          take;
        if (cpu_halted) return ST_HALT;
        if (cpu_pc == END_PC) begin
            cpu_halted = 1; return ST_HALT;
        end
        w1 = mrd(cpu_pc); cpu_pc++;
        if (w1 == 0) begin
            cpu_halted = 1; return ST_HALT;
        end
        op = w1[15:8]; ra = w1[7:4]; rb = w1[3:0];
        case (op)
            OP_NOP: return ST_OK;
            OP_LDR, OP_ADDAR, OP_SUBAR, OP_ADDLR, OP_SUBLR, OP_ANDR, OP_ORR, OP_XORR,
            OP_CPAR, OP_CPLR: begin
                if (ra < 1 || ra > 7 || rb < 1 || rb > 7) return ST_BADREG;
                a = cpu_gr[ra]; b = cpu_gr[rb];
                case (op)
                    OP_LDR: begin cpu_gr[ra] = b; put_flags(b, 0); end
                    OP_ADDAR: begin
                        res = a + b;
                        cpu_gr[ra] = res[15:0];
                        put_flags(res, (~(a[15] ^ b[15])) & (a[15] ^ res[15]));
                    end
                    OP_SUBAR: begin
                        res = a - b;
                        cpu_gr[ra] = res[15:0];
                        put_flags(res, (a[15] ^ b[15]) & (a[15] ^ res[15]));
                    end
                    OP_ADDLR: begin
                        res = {1'b0, a} + b; cpu_gr[ra] = res[15:0]; put_flags(res, res[16]);
                    end
                    OP_SUBLR: begin
                        res = a - b; cpu_gr[ra] = res[15:0]; put_flags(res, a < b);
                    end
                    OP_ANDR: begin res = a & b; cpu_gr[ra] = res[15:0]; put_flags(res, 0); end
                    OP_ORR: begin res = a | b; cpu_gr[ra] = res[15:0]; put_flags(res, 0); end
                    OP_XORR: begin res = a ^ b; cpu_gr[ra] = res[15:0]; put_flags(res, 0); end
                    OP_CPAR: cpu_flags = compare(a, b, 1);
                    default: cpu_flags = compare(a, b, 0);
                endcase
                return ST_OK;
            end
            OP_POP: begin
                if (ra < 1 || ra > 7) return ST_BADREG;
                cpu_gr[ra] = mrd(cpu_sp); cpu_sp++;
                return ST_OK;
            end
            OP_RET: begin
                if (cpu_sp == END_PC) begin
                    cpu_pc = END_PC; return ST_OK;
                end
                cpu_pc = mrd(cpu_sp); cpu_sp++;
                return ST_OK;
            end
            default: ;
        endcase
        w2 = mrd(cpu_pc); cpu_pc++;
        if (w2 == 0) begin
            cpu_halted = 1; return ST_HALT;
        end
        if (!(op inside {OP_LD, OP_ST, OP_LAD, OP_ADDA, OP_SUBA, OP_ADDL, OP_SUBL,
                         OP_AND, OP_OR, OP_XOR, OP_CPA, OP_CPL, OP_SLA, OP_SRA, OP_SLL,
                         OP_SRL, OP_JMI, OP_JNZ, OP_JZE, OP_JUMP, OP_JPL, OP_JOV,
                         OP_PUSH, OP_CALL}))
            return ST_BADOP;
        if (rb > 7) return ST_BADREG;
        ea = w2 + (rb != 0 ? cpu_gr[rb] : 16'h0);
        if (op >= OP_JMI && op <= OP_JOV) begin
            case (op)
                OP_JMI: take = cpu_flags[1];
                OP_JNZ: take = !cpu_flags[0];
                OP_JZE: take = cpu_flags[0];
                OP_JUMP: take = 1;
                OP_JPL: take = !cpu_flags[1] && !cpu_flags[0];
                default: take = cpu_flags[2];
            endcase
            if (take) cpu_pc = ea;
            return ST_OK;
        end
        if (op == OP_PUSH) begin
            cpu_sp--; mwr(cpu_sp, ea); return ST_OK;
        end
        if (op == OP_CALL) begin
            cpu_sp--; mwr(cpu_sp, cpu_pc); cpu_pc = ea; return ST_OK;
        end
        if (ra < 1 || ra > 7) return ST_BADREG;
        a = cpu_gr[ra];
        sign = a & 16'h8000;
        case (op)
            OP_LD: begin b = mrd(ea); cpu_gr[ra] = b; put_flags(b, 0); return ST_OK; end
            OP_ST: begin mwr(ea, a); return ST_OK; end
            OP_LAD: begin cpu_gr[ra] = ea; return ST_OK; end
            OP_CPA: begin cpu_flags = compare(a, mrd(ea), 1); return ST_OK; end
            OP_CPL: begin cpu_flags = compare(a, mrd(ea), 0); return ST_OK; end
            OP_SLA: begin
                if (ea == 0) begin res = a; of_bit = 0; end
                else if (ea <= 15) begin
                    res = sign | ((a << ea) & 16'h7FFF); of_bit = a[15 - ea];
                end else begin res = sign; of_bit = 0; end
            end
            OP_SRA: begin
                if (ea == 0) begin res = a; of_bit = 0; end
                else if (ea <= 15) begin
                    res = $signed(a) >>> ea; of_bit = a[ea - 1];
                end else begin res = sign[15] ? 16'hFFFF : 16'h0; of_bit = sign[15]; end
            end
            OP_SLL: begin
                if (ea == 0) begin res = a; of_bit = 0; end
                else if (ea <= 16) begin
                    res = (a << ea) & 16'hFFFF; of_bit = a[16 - ea];
                end else begin res = 0; of_bit = 0; end
            end
            OP_SRL: begin
                if (ea == 0) begin res = a; of_bit = 0; end
                else if (ea <= 16) begin res = a >> ea; of_bit = a[ea - 1]; end
                else begin res = 0; of_bit = 0; end
            end
            default: begin
                b = mrd(ea);
                case (op)
                    OP_ADDA: begin
                        res = a + b; of_bit = (~(a[15] ^ b[15])) & (a[15] ^ res[15]);
                    end
                    OP_SUBA: begin
                        res = a - b; of_bit = (a[15] ^ b[15]) & (a[15] ^ res[15]);
                    end
                    OP_ADDL: begin res = {1'b0, a} + b; of_bit = res[16]; end
                    OP_SUBL: begin res = a - b; of_bit = a < b; end
                    OP_AND: begin res = a & b; of_bit = 0; end
                    OP_OR: begin res = a | b; of_bit = 0; end
                    default: begin res = a ^ b; of_bit = 0; end
                endcase
            end
        endcase
        cpu_gr[ra] = res[15:0];
        put_flags(res, of_bit);
        return ST_OK;
    endfunction

    // Model of one request; returns the expected result.
    function automatic result_t process_request(input cmd_e c, input logic [15:0] addr,
                                               input logic [15:0] wd, input logic [3:0] sel);
        result_t r;
        r.status = ST_OK;
        r.rword = '0;
        case (c)
            CMD_WRMEM: mwr(addr, wd);
            CMD_RDMEM: r.rword = mrd(addr);
            CMD_RDREG: begin
                if (sel == 0) r.rword = {13'h0, cpu_flags};
                else if (sel <= 7) r.rword = cpu_gr[sel];
                else if (sel == 8) r.rword = cpu_pc;
                else if (sel == 9) r.rword = cpu_sp;
                else r.status = ST_BADREG;
            end
            CMD_EXEC: r.status = execute_instruction();
            CMD_RESTART: begin
                cpu_pc = cfg_start; cpu_sp = cfg_stack; cpu_halted = 0;
            end
            default: ;
        endcase
        r.pc = cpu_pc;
        r.flags = cpu_flags;
        return r;
    endfunction

    // Random gap: mostly short, now and then long.
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one request and records the expected result once accepted.
    // Valid stays high into the next request when there is no gap.
    task automatic send_request(input logic [2:0] c, input logic [15:0] addr,
                                input logic [15:0] wd, input logic [3:0] sel);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, sel, wd, addr, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(process_request(cmd_e'(c), addr, wd, sel));
    endtask

    task automatic write_word(input logic [15:0] addr, input logic [15:0] v);
        send_request(CMD_WRMEM, addr, v, 4'($urandom_range(0, 15)));
    endtask

    task automatic exec_one();
        send_request(CMD_EXEC, 16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_config(input logic idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        if (idx == 1'b0) cfg_start = v;
        else cfg_stack = v;
    endtask

    // Picks an opcode, now and then a random byte.
    function automatic logic [7:0] pick_opcode();
        logic [7:0] ops [37] = '{OP_NOP, OP_LD, OP_ST, OP_LAD, OP_LDR, OP_ADDA, OP_SUBA,
            OP_ADDL, OP_SUBL, OP_ADDAR, OP_SUBAR, OP_ADDLR, OP_SUBLR, OP_AND, OP_OR, OP_XOR,
            OP_ANDR, OP_ORR, OP_XORR, OP_CPA, OP_CPL, OP_CPAR, OP_CPLR, OP_SLA, OP_SRA,
            OP_SLL, OP_SRL, OP_JMI, OP_JNZ, OP_JZE, OP_JUMP, OP_JPL, OP_JOV, OP_PUSH,
            OP_POP, OP_CALL, OP_RET};
        if ($urandom_range(0, 29) == 0) return 8'($urandom);
        return ops[$urandom_range(0, 36)];
    endfunction

    // Places one instruction and its data so that every read hits a written word.
    task automatic place_and_run(input logic [7:0] op, input logic [3:0] ra,
                                 input logic [3:0] rx, input logic [15:0] adr);
        logic [15:0] ea;
        write_word(cpu_pc, {op, ra, rx});
        write_word(cpu_pc + 16'd1, adr);
        ea = adr + ((rx >= 1 && rx <= 7) ? cpu_gr[rx] : 16'h0);
        if (!mem_valid[ea]) write_word(ea, 16'($urandom));
        if (!mem_valid[cpu_sp]) write_word(cpu_sp, 16'($urandom));
        exec_one();
    endtask

    task automatic random_instruction();
        logic [7:0]  op;
        logic [3:0]  ra, rx;
        logic [15:0] adr;
        op = pick_opcode();
        ra = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(1, 7));
        rx = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
        if (op >= OP_SLA && op <= OP_SRL && $urandom_range(0, 3) != 0) begin
            adr = 16'($urandom_range(1, 17)); rx = 0;
        end else if ($urandom_range(0, 2) == 0) begin
            adr = 16'h0100 + 16'($urandom_range(0, 31));
        end else begin
            adr = 16'($urandom);
        end
        if (adr == 0) adr = 1;
        place_and_run(op, ra, rx, adr);
    endtask

    // Restarts the program at a fresh place in memory.
    task automatic restart_at(input logic [15:0] pc, input logic [15:0] sp);
        drain();
        write_config(1'b0, pc);
        write_config(1'b1, sp);
        cfg_we <= 1'b0;
        send_request(CMD_RESTART, 16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    task automatic test_directed();
        logic [7:0] ops [8] = '{OP_ADDAR, OP_SUBAR, OP_ADDLR, OP_SUBLR,
                                OP_CPAR, OP_CPLR, OP_ANDR, OP_LDR};
        // Registers take extremes through LAD.
        place_and_run(OP_LAD, 4'd1, 4'd0, 16'h7FFF);
        place_and_run(OP_LAD, 4'd2, 4'd0, 16'h8000);
        place_and_run(OP_LAD, 4'd3, 4'd0, 16'hFFFF);
        foreach (ops[i]) begin
            write_word(cpu_pc, {ops[i], 4'd1, 4'd2});
            exec_one();
        end
        // Bad register index in a one-word form, and an unknown opcode.
        write_word(cpu_pc, {OP_ADDAR, 4'd0, 4'd2}); exec_one();
        place_and_run(8'hFF, 4'd1, 4'd1, 16'h1234);
        // Shift by a count of zero is given through an index register.
        place_and_run(OP_LAD, 4'd4, 4'd0, 16'hFFFF);
        place_and_run(OP_SRA, 4'd2, 4'd4, 16'h0001);
        // Register reads, including the bad selectors.
        for (int s = 0; s < 16; s++) send_request(CMD_RDREG, 16'd0, 16'd0, 4'(s));
        send_request(3'd5, 16'hFFFF, 16'hFFFF, 4'hF);
        // An all-zero word halts; a second execute stays halted.
        write_word(cpu_pc, 16'h0); exec_one(); exec_one();
        // RET with SP at the end sentinel, then the fetch at the sentinel halts.
        restart_at(16'h2000, END_PC);
        write_word(16'h2000, {OP_RET, 8'hFF}); exec_one(); exec_one();
    endtask

    task automatic test_random_programs();
        int n;
        logic [15:0] ad;
        for (int k = 0; k < 14; k++) begin
            restart_at(k[0] ? 16'h0 + 16'(k * 40) : 16'($urandom_range(16'h3000, 16'h7000)),
                       (k % 5 == 0) ? 16'hFFFF : 16'($urandom_range(16'h9000, 16'hFF00)));
            n = $urandom_range(8, 20);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: send_request(CMD_RDREG, 16'($urandom), 16'($urandom),
                                    4'($urandom_range(0, 15)));
                    1: begin
                        ad = 16'h0100 + 16'($urandom_range(0, 31));
                        if (!mem_valid[ad]) write_word(ad, 16'($urandom));
                        send_request(CMD_RDMEM, ad, 16'($urandom), 4'($urandom));
                    end
                    2: send_request(CMD_WRMEM, 16'h0100 + 16'($urandom_range(0, 31)),
                                    16'($urandom), 4'($urandom));
                    default: begin
                        if (cpu_halted) send_request(CMD_RESTART, 16'd0, 16'd0, 4'd0);
                        else random_instruction();
                    end
                endcase
            end
        end
    endtask

    // The receiver holds off while requests keep coming, so the queue fills up.
    task automatic test_backpressure();
        restart_at(16'h1800, 16'hF000);
        hold_cycles = 200;
        for (int i = 0; i < 30; i++)
            send_request(CMD_RDREG, 16'd0, 16'd0, 4'($urandom_range(0, 9)));
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver readiness: random stalls, and a long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70) ||
                        ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
        end
    end

    // Compares each delivered result with the oldest expectation.
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_e'(m_tdata[1:0]);
            got.rword  = m_tdata[17:2];
            got.pc     = m_tdata[33:18];
            got.flags  = m_tdata[36:34];
            if (expected_results.size() == 0) begin
                $error("result with no request pending: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.rword != want.rword) begin
                    $error("read_word: expected %h, actual %h", want.rword, got.rword);
                    error_count++;
                end
                if (got.pc != want.pc) begin
                    $error("pc_now: expected %h, actual %h", want.pc, got.pc);
                    error_count++;
                end
                if (got.flags != want.flags) begin
                    $error("flag_bits: expected %b, actual %b", want.flags, got.flags);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (cpu_mem[i]) begin
            cpu_mem[i] = 16'h0;
            mem_valid[i] = 1'b0;
        end
        for (int r = 1; r <= 7; r++) cpu_gr[r] = 16'h0;
        cfg_start = 16'h0;
        cfg_stack = 16'hFFFF;
        cpu_pc = 16'h0;
        cpu_sp = 16'hFFFF;
        cpu_flags = 3'b0;
        cpu_halted = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random_programs();
        // Sender pauses until everything has come back, then more programs run.
        drain();
        test_random_programs();
        restart_at(16'hFFFF, 16'h0000);
        exec_one();
        drain();
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
